// File: hdl/oiwf_pkg.sv
// ----------------------------------------------------------------------------
// oiwf_pkg: shared types and constants of the write framer
// Word descriptor between front and back, symbol codes, sequencer phases.
// ----------------------------------------------------------------------------
package oiwf_pkg;

    localparam int BYTE_W = 8;
    localparam int BIT_W  = 4;                  // bit counter, holds 0..8
    localparam logic [BIT_W-1:0] ACK_SLOT = 4'd8;
    localparam logic [2:0]       MSB_IDX  = 3'd7;

    localparam logic [BYTE_W-1:0] CTRL_COMMAND = 8'h00;
    localparam logic [BYTE_W-1:0] CTRL_DATA    = 8'h40;
    localparam logic [BYTE_W-1:0] ADDR_RESET   = 8'h78;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;                 // index bits for Q_DEPTH
    localparam int Q_CW    = Q_AW + 1;          // count holds 0..Q_DEPTH

    typedef enum logic [1:0] {
        KIND_CLOCK = 2'd0,
        KIND_START = 2'd1,
        KIND_STOP  = 2'd2
    } symbol_kind_t;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_START,
        PH_ADDR,
        PH_CTRL,
        PH_DATA,
        PH_STOP
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload;
        logic [BYTE_W-1:0] ctrl_byte;
        logic              opens;
        logic              closes;
    } item_t;

    typedef struct packed {
        logic            full;
        logic            empty;
        logic [Q_CW-1:0] count;
    } q_status_t;

endpackage

// File: hdl/oiwf_front.sv
// ----------------------------------------------------------------------------
// oiwf_front: input word capture and classification
// Registers one input word and turns it into a descriptor for the queue.
// ----------------------------------------------------------------------------
module oiwf_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_payload,
    input  logic                  in_is_data,
    input  logic                  in_opens,
    input  logic                  in_closes,
    output logic                  out_valid,
    input  logic                  out_ready,
    output oiwf_pkg::item_t       out_item
);

    logic            valid_reg, valid_next;
    oiwf_pkg::item_t item_reg, item_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (out_ready) begin
            valid_next = 1'b0;
        end
        if (in_valid && in_ready) begin
            valid_next          = 1'b1;
            item_next.payload   = in_payload;
            item_next.ctrl_byte = in_is_data ? oiwf_pkg::CTRL_DATA : oiwf_pkg::CTRL_COMMAND;
            item_next.opens     = in_opens;
            item_next.closes    = in_closes;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule

// File: hdl/oiwf_queue.sv
// ----------------------------------------------------------------------------
// oiwf_queue: short descriptor queue
// Decouples the front from the symbol sequencer; head is read in place.
// ----------------------------------------------------------------------------
module oiwf_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    output logic                  push_ready,
    input  oiwf_pkg::item_t       push_item,
    output logic                  head_valid,
    input  logic                  pop,
    output oiwf_pkg::item_t       head_item,
    output oiwf_pkg::q_status_t   status
);

    oiwf_pkg::item_t                entry_reg [oiwf_pkg::Q_DEPTH];
    logic [oiwf_pkg::Q_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [oiwf_pkg::Q_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [oiwf_pkg::Q_CW-1:0]      count_reg, count_next;
    logic                           do_push, do_pop;

    assign status.full  = (count_reg == oiwf_pkg::Q_CW'(oiwf_pkg::Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

    assign push_ready = !status.full;
    assign head_valid = !status.empty;
    assign head_item  = entry_reg[rd_ptr_reg];

    assign do_push = push && push_ready;
    assign do_pop  = pop && head_valid;

    // pointers wrap at the depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == oiwf_pkg::Q_AW'(oiwf_pkg::Q_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == oiwf_pkg::Q_AW'(oiwf_pkg::Q_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hdl/oiwf_back.sv
// ----------------------------------------------------------------------------
// oiwf_back: bus symbol sequencer
// Walks start, address and control (opening heads), payload and stop (closing
// heads), one symbol per cycle unless stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module oiwf_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [7:0]            slave_addr,
    input  logic                  head_valid,
    input  oiwf_pkg::item_t       head_item,
    output logic                  pop,
    output logic                  sym_valid,
    input  logic                  sym_ready,
    output oiwf_pkg::symbol_kind_t sym_kind,
    output logic                  sym_sda,
    output logic                  sym_last
);

    oiwf_pkg::phase_t               phase_reg, phase_next, cur_phase;
    logic [oiwf_pkg::BIT_W-1:0]     bit_reg, bit_next;
    logic                           out_valid_reg, out_valid_next;
    oiwf_pkg::symbol_kind_t         out_kind_reg, out_kind_next;
    logic                           out_sda_reg, out_sda_next;
    logic                           out_last_reg, out_last_next;
    logic                           advance, fire, ack_slot;
    logic [oiwf_pkg::BYTE_W-1:0]    cur_byte;
    oiwf_pkg::symbol_kind_t         kind;
    logic                           sda, last;

    assign advance  = !out_valid_reg || sym_ready;
    assign fire     = head_valid && advance;
    assign ack_slot = (bit_reg == oiwf_pkg::ACK_SLOT);

    // a fresh head starts with its header only when it opens a frame
    always_comb begin
        cur_phase = phase_reg;
        if (phase_reg == oiwf_pkg::PH_FIRST) begin
            cur_phase = head_item.opens ? oiwf_pkg::PH_START : oiwf_pkg::PH_DATA;
        end
    end

    // symbol outputs
    always_comb begin
        kind     = oiwf_pkg::KIND_CLOCK;
        sda      = 1'b0;
        last     = 1'b0;
        cur_byte = head_item.payload;
        case (cur_phase)
            oiwf_pkg::PH_ADDR: cur_byte = slave_addr;
            oiwf_pkg::PH_CTRL: cur_byte = head_item.ctrl_byte;
            default:           cur_byte = head_item.payload;
        endcase
        case (cur_phase)
            oiwf_pkg::PH_START: begin
                kind = oiwf_pkg::KIND_START;
            end
            oiwf_pkg::PH_STOP: begin
                kind = oiwf_pkg::KIND_STOP;
                last = 1'b1;
            end
            oiwf_pkg::PH_ADDR, oiwf_pkg::PH_CTRL, oiwf_pkg::PH_DATA: begin
                sda = ack_slot ? 1'b1 : cur_byte[oiwf_pkg::MSB_IDX - bit_reg[2:0]];
                if (cur_phase == oiwf_pkg::PH_DATA && ack_slot && !head_item.closes) begin
                    last = 1'b1;
                end
            end
            default: begin
                kind = oiwf_pkg::KIND_CLOCK;
            end
        endcase
        pop = fire && last;
    end

    // next state
    always_comb begin
        phase_next = phase_reg;
        bit_next   = bit_reg;
        if (fire) begin
            case (cur_phase)
                oiwf_pkg::PH_START: begin
                    phase_next = oiwf_pkg::PH_ADDR;
                    bit_next   = '0;
                end
                oiwf_pkg::PH_ADDR: begin
                    bit_next   = ack_slot ? '0 : bit_reg + 1'b1;
                    phase_next = ack_slot ? oiwf_pkg::PH_CTRL : oiwf_pkg::PH_ADDR;
                end
                oiwf_pkg::PH_CTRL: begin
                    bit_next   = ack_slot ? '0 : bit_reg + 1'b1;
                    phase_next = ack_slot ? oiwf_pkg::PH_DATA : oiwf_pkg::PH_CTRL;
                end
                oiwf_pkg::PH_DATA: begin
                    bit_next = ack_slot ? '0 : bit_reg + 1'b1;
                    if (ack_slot) begin
                        phase_next = head_item.closes ? oiwf_pkg::PH_STOP : oiwf_pkg::PH_FIRST;
                    end else begin
                        phase_next = oiwf_pkg::PH_DATA;
                    end
                end
                oiwf_pkg::PH_STOP: begin
                    phase_next = oiwf_pkg::PH_FIRST;
                    bit_next   = '0;
                end
                default: begin
                    phase_next = oiwf_pkg::PH_FIRST;
                    bit_next   = '0;
                end
            endcase
        end
    end

    // output stage
    always_comb begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_sda_next   = out_sda_reg;
        out_last_next  = out_last_reg;
        if (advance) begin
            out_valid_next = head_valid;
            out_kind_next  = kind;
            out_sda_next   = sda;
            out_last_next  = last;
        end
    end

    assign sym_valid = out_valid_reg;
    assign sym_kind  = out_kind_reg;
    assign sym_sda   = out_sda_reg;
    assign sym_last  = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= oiwf_pkg::PH_FIRST;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
        out_kind_reg <= out_kind_next;
        out_sda_reg  <= out_sda_next;
        out_last_reg <= out_last_next;
    end

endmodule

// File: hdl/oled_i2c_write_framer_core.sv
// ----------------------------------------------------------------------------
// oled_i2c_write_framer_core: write-only I2C framer for a display controller
// Turns byte words into a stream of bus symbols (start, bit clock, stop).
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per byte to send. s_tdata[7:0] is the byte,
//   s_tdata[8] opens a frame (start + address byte + control byte first),
//   s_tuser selects data (control 0x40) or command (control 0x00), s_tlast
//   closes the frame with a stop after the byte.
//   m_ channel: one word per bus symbol. m_tuser is the kind (clock, start,
//   stop), m_tdata[0] the SDA level during a clock (1 in the ack slot),
//   m_tlast marks the last symbol produced for an input word.
//   cfg_we/cfg_wdata: slave address byte (write bit included), 0x78 at reset.
//   Write it only while the block is idle.
// Timing:
//   First symbol words pass the front register, queue and output stage. The
//   sequencer puts out one symbol per cycle unless m_tready stalls it; start,
//   address and control bytes and a stop frame a byte as its word asks. The
//   front stage and a 2-deep queue keep s_tready up while the sequencer works.
// Reset clears the queue, the sequencer and the output stage. When m_tready
// is low the output word holds and the sequencer stalls; the front keeps
// taking words until the queue and the front register are full.
// ----------------------------------------------------------------------------
module oled_i2c_write_framer_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [7:0] payload_byte, [8] opens_frame, rest zero
    input  logic        s_tuser,    // [0] is_data
    input  logic        s_tlast,    // closes_frame
    // symbol words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [0] sda_level, rest zero
    output logic [1:0]  m_tuser,    // [1:0] symbol_kind
    output logic        m_tlast,    // last_of_run
    // slave address register
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    logic [7:0]              slave_addr_reg;
    logic                    front_valid, front_ready;
    oiwf_pkg::item_t         front_item;
    logic                    head_valid, head_pop;
    oiwf_pkg::item_t         head_item;
    oiwf_pkg::q_status_t     q_status;
    oiwf_pkg::symbol_kind_t  sym_kind;
    logic                    sym_sda;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_addr_reg <= oiwf_pkg::ADDR_RESET;
        end else if (cfg_we) begin
            slave_addr_reg <= cfg_wdata;
        end
    end

    // front: capture and classify each word
    oiwf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_payload (s_tdata[7:0]),
        .in_is_data (s_tuser),
        .in_opens   (s_tdata[8]),
        .in_closes  (s_tlast),
        .out_valid  (front_valid),
        .out_ready  (front_ready),
        .out_item   (front_item)
    );

    // queue between front and sequencer
    oiwf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .head_valid (head_valid),
        .pop        (head_pop),
        .head_item  (head_item),
        .status     (q_status)
    );

    // back: symbol sequencer with registered output
    oiwf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .slave_addr (slave_addr_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (head_pop),
        .sym_valid  (m_tvalid),
        .sym_ready  (m_tready),
        .sym_kind   (sym_kind),
        .sym_sda    (sym_sda),
        .sym_last   (m_tlast)
    );

    assign m_tuser = sym_kind;
    assign m_tdata = {7'd0, sym_sda};

    // a stop always ends the run of its word
    a_stop_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == oiwf_pkg::KIND_STOP |-> m_tlast)
        else $error("stop symbol without last flag");

    // a start is never the final symbol of a word
    a_start_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == oiwf_pkg::KIND_START |-> !m_tlast)
        else $error("start symbol flagged last");

    // start and stop carry SDA low
    a_cond_sda_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == oiwf_pkg::KIND_START || m_tuser == oiwf_pkg::KIND_STOP)
        |-> m_tdata[0] == 1'b0)
        else $error("bus condition with SDA high");

    // queue occupancy stays in range and pops only with a head
    a_queue_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.count <= oiwf_pkg::Q_CW'(oiwf_pkg::Q_DEPTH) && (!head_pop || head_valid))
        else $error("queue occupancy out of range");

endmodule
